>>> rtl/ihct_pkg.sv
package ihct_pkg;

   // Field widths of one entry and of the request and response payloads.
   localparam int KEY_BITS    = 16;
   localparam int REC_BITS    = 32;
   localparam int ENTRY_BITS  = KEY_BITS + REC_BITS;
   localparam int MODE_BITS   = 2;
   localparam int STATUS_BITS = 2;

   // Default geometry handed to the top level.
   localparam int DEF_BUCKET_COUNT = 32;
   localparam int DEF_CHAIN_DEPTH  = 8;

   typedef logic [MODE_BITS-1:0] op_type;

   // Operation codes, equal to the request mode codes.
   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_FIND   = 2'd1;
   localparam op_type OP_DELETE = 2'd2;
   localparam op_type OP_NOP    = 2'd3;

   // Response status codes.
   localparam logic [STATUS_BITS-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      op_type              op;
      logic [KEY_BITS-1:0] key;
      logic [REC_BITS-1:0] rec;
   } cmd_type;

   // Status of the back part, watched by the top level.
   typedef struct packed {
      logic fire;
      logic row_write;
   } back_status_type;

endpackage

>>> rtl/ihct_queue.sv
module ihct_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   // Two-entry queue between the front and the back part.
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       fill_ff;
   logic [1:0]       fill_in;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/ihct_front.sv
module ihct_front #(
   parameter int BUCKET_COUNT = ihct_pkg::DEF_BUCKET_COUNT,
   parameter int BUCKET_BITS  = $clog2(BUCKET_COUNT)
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   input  logic [ihct_pkg::ENTRY_BITS-1:0]              req_tdata,
   input  logic [ihct_pkg::MODE_BITS-1:0]               req_tuser,
   output logic                                         push,
   output ihct_pkg::cmd_type                            push_cmd,
   output logic [BUCKET_BITS-1:0]                       push_bucket,
   input  logic                                         q_full
);

   // The bucket is the key modulo BUCKET_COUNT, taken as a multiplication
   // by a rounded-up reciprocal, which is exact for 16-bit keys, and then a
   // subtraction with one guard compare.
   localparam int              KB       = ihct_pkg::KEY_BITS;
   localparam int              SHIFT    = KB + $clog2(BUCKET_COUNT);
   localparam int              PRODW    = 48;
   localparam longint unsigned RECIP    =
      ((64'd1 << SHIFT) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT);

   logic              stg_valid_ff;
   logic              stg_valid_in;
   ihct_pkg::cmd_type stg_cmd_ff;
   ihct_pkg::cmd_type stg_cmd_in;
   logic [KB-1:0]     stg_quot_ff;
   logic [KB-1:0]     stg_quot_in;
   logic [PRODW-1:0]  prod;
   logic [KB-1:0]     rem_raw;
   logic [KB-1:0]     rem_fix;
   logic              accept;

   assign push       = stg_valid_ff && !q_full;
   assign req_tready = !stg_valid_ff || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign prod       = PRODW'(req_tdata[KB-1:0]) * PRODW'(RECIP);

   always_comb begin
      stg_cmd_in.key = req_tdata[KB-1:0];
      stg_cmd_in.rec = req_tdata[ihct_pkg::ENTRY_BITS-1:KB];
      unique case (req_tuser)
         ihct_pkg::OP_INSERT: stg_cmd_in.op = ihct_pkg::OP_INSERT;
         ihct_pkg::OP_FIND:   stg_cmd_in.op = ihct_pkg::OP_FIND;
         ihct_pkg::OP_DELETE: stg_cmd_in.op = ihct_pkg::OP_DELETE;
         default:             stg_cmd_in.op = ihct_pkg::OP_NOP;
      endcase
      stg_quot_in  = prod[SHIFT +: KB];
      stg_valid_in = accept ? 1'b1 : (push ? 1'b0 : stg_valid_ff);
   end

   always_comb begin
      rem_raw = stg_cmd_ff.key - KB'(32'(stg_quot_ff) * 32'(BUCKET_COUNT));
      rem_fix = (rem_raw >= KB'(BUCKET_COUNT)) ? rem_raw - KB'(BUCKET_COUNT) : rem_raw;
   end

   assign push_cmd    = stg_cmd_ff;
   assign push_bucket = rem_fix[BUCKET_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_cmd_ff  <= stg_cmd_in;
         stg_quot_ff <= stg_quot_in;
      end
   end

endmodule

>>> rtl/ihct_back.sv
module ihct_back #(
   parameter int BUCKET_COUNT = ihct_pkg::DEF_BUCKET_COUNT,
   parameter int CHAIN_DEPTH  = ihct_pkg::DEF_CHAIN_DEPTH,
   parameter int BUCKET_BITS  = $clog2(BUCKET_COUNT)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  ihct_pkg::cmd_type                    q_cmd,
   input  logic [BUCKET_BITS-1:0]               q_bucket,
   output logic                                 q_pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ihct_pkg::REC_BITS-1:0]        rsp_tdata,
   output logic [ihct_pkg::STATUS_BITS:0]       rsp_tuser,
   output ihct_pkg::back_status_type            status
);

   localparam int KB       = ihct_pkg::KEY_BITS;
   localparam int RB       = ihct_pkg::REC_BITS;
   localparam int EB       = ihct_pkg::ENTRY_BITS;
   localparam int ROW_BITS = EB * CHAIN_DEPTH;
   localparam int CNT_BITS = $clog2(CHAIN_DEPTH + 1);

   localparam logic S_READ = 1'b0;
   localparam logic S_EXEC = 1'b1;

   // One memory row holds a whole bucket chain, entry i at bits i*EB.
   logic [ROW_BITS-1:0]    mem_q [BUCKET_COUNT];
   logic [ROW_BITS-1:0]    row_ff;
   logic [ROW_BITS-1:0]    row_up;
   logic [ROW_BITS-1:0]    row_new;
   logic [CNT_BITS-1:0]    counts_ff [BUCKET_COUNT];
   logic                   state_ff;
   logic                   state_in;
   ihct_pkg::cmd_type      cmd_ff;
   logic [BUCKET_BITS-1:0] bucket_ff;
   logic [CNT_BITS-1:0]    count;
   logic [CNT_BITS-1:0]    count_new;
   logic [CHAIN_DEPTH-1:0] match;
   logic [CHAIN_DEPTH-1:0] first;
   logic [CHAIN_DEPTH-1:0] at_or_above;
   logic                   hit;
   logic                   full;
   logic [RB-1:0]          hit_rec;
   logic                   fire;
   logic                   wr_en;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_hit_ff;
   logic                   rsp_hit_in;
   logic [RB-1:0]          rsp_rec_ff;
   logic [RB-1:0]          rsp_rec_in;
   logic [ihct_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic [ihct_pkg::STATUS_BITS-1:0] rsp_status_in;

   assign q_pop = (state_ff == S_READ) && q_valid;
   assign fire  = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign count = counts_ff[bucket_ff];
   assign full  = (count == CNT_BITS'(CHAIN_DEPTH));

   // Parallel compare of the chain, first match in chain order.
   always_comb begin
      for (int i = 0; i < CHAIN_DEPTH; i++) begin
         match[i] = (CNT_BITS'(i) < count) && (row_ff[i*EB +: KB] == cmd_ff.key);
      end
      first       = match & (~match + CHAIN_DEPTH'(1));
      at_or_above = ~(first - CHAIN_DEPTH'(1));
      hit         = |match;
      hit_rec     = '0;
      for (int i = 0; i < CHAIN_DEPTH; i++) begin
         hit_rec = hit_rec | (first[i] ? row_ff[i*EB + KB +: RB] : RB'(0));
      end
   end

   // New row: insert writes the tail slot, delete pulls later entries down.
   always_comb begin
      row_up  = ROW_BITS'({{EB{1'b0}}, row_ff} >> EB);
      row_new = row_ff;
      for (int i = 0; i < CHAIN_DEPTH; i++) begin
         if (cmd_ff.op == ihct_pkg::OP_INSERT) begin
            if (CNT_BITS'(i) == count) begin
               row_new[i*EB +: EB] = {cmd_ff.rec, cmd_ff.key};
            end
         end else if (at_or_above[i]) begin
            row_new[i*EB +: EB] = row_up[i*EB +: EB];
         end
      end
   end

   always_comb begin
      wr_en         = 1'b0;
      count_new     = count;
      rsp_hit_in    = 1'b0;
      rsp_rec_in    = '0;
      rsp_status_in = ihct_pkg::ST_DONE;
      unique case (cmd_ff.op)
         ihct_pkg::OP_INSERT: begin
            if (full) begin
               rsp_status_in = ihct_pkg::ST_FULL;
            end else begin
               wr_en     = fire;
               count_new = count + CNT_BITS'(1);
            end
         end
         ihct_pkg::OP_FIND: begin
            rsp_hit_in    = hit;
            rsp_rec_in    = hit_rec;
            rsp_status_in = hit ? ihct_pkg::ST_DONE : ihct_pkg::ST_MISS;
         end
         ihct_pkg::OP_DELETE: begin
            rsp_hit_in    = hit;
            rsp_status_in = hit ? ihct_pkg::ST_DONE : ihct_pkg::ST_MISS;
            if (hit) begin
               wr_en     = fire;
               count_new = count - CNT_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      if (q_pop) begin
         state_in = S_EXEC;
      end else if (fire) begin
         state_in = S_READ;
      end
      rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_READ;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < BUCKET_COUNT; b++) begin
            counts_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            counts_ff[bucket_ff] <= count_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff    <= q_cmd;
         bucket_ff <= q_bucket;
         row_ff    <= mem_q[q_bucket];
      end
      if (wr_en) begin
         mem_q[bucket_ff] <= row_new;
      end
      if (fire) begin
         rsp_hit_ff    <= rsp_hit_in;
         rsp_rec_ff    <= rsp_rec_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_rec_ff;
   assign rsp_tuser        = {rsp_status_ff, rsp_hit_ff};
   assign status.fire      = fire;
   assign status.row_write = wr_en;

endmodule

>>> rtl/inode_hash_cache_table.sv
// Channel   Direction  Payload
// req_      in         tdata: inode_key[15:0], record_word[47:16]; tuser: mode[1:0]
// rsp_      out        tdata: found_record[31:0]; tuser: hit[0], status[2:1]
//
// The back part takes a new request only after the last one completes: the
// bucket row is read from the chain memory in the read state and compared
// and written back in the execute state, which waits for the response slot.
// A request passes through the front stage, the queue and the row read, and
// the compare and write-back then load the response registers.
// Reset is synchronous and clears the chain counts at once, so no clearing
// pass is needed. A stalled response holds only the back part; the two-entry
// queue lets the front keep accepting requests until the queue fills.
module inode_hash_cache_table #(
   parameter int BUCKET_COUNT = ihct_pkg::DEF_BUCKET_COUNT,
   parameter int CHAIN_DEPTH  = ihct_pkg::DEF_CHAIN_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // inode_key [15:0], record_word [47:16]
   input  logic [ihct_pkg::ENTRY_BITS-1:0]     req_tdata,
   // mode [1:0]
   input  logic [ihct_pkg::MODE_BITS-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // found_record [31:0]
   output logic [ihct_pkg::REC_BITS-1:0]       rsp_tdata,
   // hit [0], status [2:1]
   output logic [ihct_pkg::STATUS_BITS:0]      rsp_tuser
);

   // Width of a bucket index, and of one queued request with its bucket.
   localparam int BUCKET_BITS = $clog2(BUCKET_COUNT);
   localparam int CMD_BITS    = $bits(ihct_pkg::cmd_type);
   localparam int QW          = CMD_BITS + BUCKET_BITS;

   logic                            push;
   ihct_pkg::cmd_type               push_cmd;
   logic [BUCKET_BITS-1:0]          push_bucket;
   logic                            q_full;
   logic                            q_empty;
   logic                            q_pop;
   logic [QW-1:0]                   q_data;
   ihct_pkg::cmd_type               q_cmd;
   logic [BUCKET_BITS-1:0]          q_bucket;
   ihct_pkg::back_status_type       back_status;

   // The front decodes the request kind and works out the bucket.
   ihct_front #(
      .BUCKET_COUNT (BUCKET_COUNT),
      .BUCKET_BITS  (BUCKET_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .push        (push),
      .push_cmd    (push_cmd),
      .push_bucket (push_bucket),
      .q_full      (q_full)
   );

   // The queue decouples the front from a stalled back part.
   ihct_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_cmd, push_bucket}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   assign q_cmd    = q_data[QW-1:BUCKET_BITS];
   assign q_bucket = q_data[BUCKET_BITS-1:0];

   // The back part owns the chain memory, the counts and the response.
   ihct_back #(
      .BUCKET_COUNT (BUCKET_COUNT),
      .CHAIN_DEPTH  (CHAIN_DEPTH),
      .BUCKET_BITS  (BUCKET_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (!q_empty),
      .q_cmd      (q_cmd),
      .q_bucket   (q_bucket),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .status     (back_status)
   );

   // The front must never push into a full queue.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full) else $error("request pushed into a full queue");

   // The back part must never pop an empty queue.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("request popped from an empty queue");

   // A row is written back only when the request really completes.
   a_write_on_fire: assert property (@(posedge clock) disable iff (reset)
      back_status.row_write |-> back_status.fire)
      else $error("chain row written while the response was stalled");

   // Completions are always separated by a read state.
   a_fire_spacing: assert property (@(posedge clock) disable iff (reset)
      back_status.fire |=> !back_status.fire)
      else $error("two requests completed in consecutive cycles");

   // A new response appears only after a completion.
   a_rsp_after_fire: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(back_status.fire))
      else $error("response raised without a completed request");

endmodule
